FILE: sv/mrsd_pkg.sv
// Mixed-radix selector digits: shared types and constants.
// Used by mrsd_cell, mrsd_emit and mixed_radix_selector_digits; no dependencies.
`default_nettype none

package mrsd_pkg;

  localparam int NSIDES     = 4;
  localparam int POS_W      = 32;
  localparam int RADIX_W    = 9;
  localparam int DIGIT_W    = 8;
  localparam int FLAT_W     = 10;
  localparam int SIDE_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int BITS_PER_CELL = 8;
  localparam int CELLS_PER_SIDE = POS_W / BITS_PER_CELL;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd16;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE_SIZE_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_SIZE_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_SIZE_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_SIZE_3 = 8'd3;

  typedef logic [NSIDES-1:0][DIGIT_W-1:0] digits_t;
  typedef logic [NSIDES-1:0][FLAT_W-1:0]  offsets_t;

  typedef struct packed {
    logic                valid;
    logic [POS_W-1:0]    word;
    logic [DIGIT_W-1:0]  rem;
    digits_t             digits;
  } cell_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    e = r;
    if (r == '0) begin
      e = 9'd1;
    end else if (r > RADIX_MAX) begin
      e = RADIX_MAX;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mrsd_cell.sv
// One division cell: eight restoring-division steps on the running word.
// Depends on mrsd_pkg.
`default_nettype none

module mrsd_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic [mrsd_pkg::RADIX_W-1:0]  radix,
  input  wire logic [mrsd_pkg::SIDE_W-1:0]   side,
  input  wire logic                          deposit,
  input  wire mrsd_pkg::cell_t               d_in,
  output mrsd_pkg::cell_t                    q
);

  mrsd_pkg::cell_t q_next;

  always_comb begin
    logic [mrsd_pkg::POS_W-1:0]   w;
    logic [mrsd_pkg::DIGIT_W-1:0] rm;
    logic [mrsd_pkg::RADIX_W-1:0] t;
    w = d_in.word;
    rm = d_in.rem;
    for (int i = 0; i < mrsd_pkg::BITS_PER_CELL; i++) begin
      t = {rm, w[mrsd_pkg::POS_W-1]};
      w = {w[mrsd_pkg::POS_W-2:0], 1'b0};
      if (t >= radix) begin
        t = t - radix;
        w[0] = 1'b1;
      end
      rm = t[mrsd_pkg::DIGIT_W-1:0];
    end
    q_next = d_in;
    q_next.word = w;
    q_next.rem = rm;
    if (deposit) begin
      q_next.digits[side] = rm;
      q_next.rem = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mrsd_emit.sv
// Result stage: holds the digits of one position and hands them out one per item.
// Depends on mrsd_pkg.
`default_nettype none

module mrsd_emit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mrsd_pkg::cell_t               tail,
  input  wire mrsd_pkg::offsets_t            offsets,
  input  wire logic [mrsd_pkg::SIDE_W-1:0]   last_side,
  output logic                               load_ok,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mrsd_pkg::SIDE_W-1:0]        side_index,
  output logic [mrsd_pkg::DIGIT_W-1:0]       digit,
  output logic [mrsd_pkg::FLAT_W-1:0]        flat_index,
  output logic                               last
);

  logic                          valid;
  logic [mrsd_pkg::SIDE_W-1:0]   idx;
  mrsd_pkg::digits_t             digits;
  logic                          take;
  logic                          done;

  assign take    = valid && out_ready;
  assign done    = take && (idx == last_side);
  assign load_ok = !valid || done;

  assign out_valid  = valid;
  assign side_index = idx;
  assign digit      = digits[idx];
  assign flat_index = offsets[idx] + {2'b00, digits[idx]};
  assign last       = (idx == last_side);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (tail.valid && load_ok) begin
      valid  <= 1'b1;
      idx    <= '0;
      digits <= tail.digits;
    end else if (take) begin
      if (done) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/mixed_radix_selector_digits.sv
// Top level: configuration registers, row of division cells, result stage.
// Depends on mrsd_pkg, mrsd_cell and mrsd_emit.
`default_nettype none

// Splits a 32-bit position into DEGREE mixed-radix digits, side DEGREE-1
// least significant, and returns one item per side in order 0..DEGREE-1
// with the digit and its flat index (sum of earlier side sizes plus digit).
// Side sizes of 0 act as 1 and sizes above 256 act as 256. The digits come
// from a row of 4*DEGREE cells, each retiring eight quotient bits per cycle
// unless the row stalls; the last cell feeds the result stage register. The
// row takes a new position every cycle but stalls while the result stage is
// busy; that stage hands out one digit per cycle while out_ready is high.
// Configuration writes are taken in any cycle (cfg_ready is always high);
// the user must make them only while idle, as the block does not enforce it.

module mixed_radix_selector_digits #(
  parameter int DEGREE = 2
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mrsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mrsd_pkg::RADIX_W-1:0]     cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mrsd_pkg::POS_W-1:0]       position,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mrsd_pkg::SIDE_W-1:0]           side_index,
  output logic [mrsd_pkg::DIGIT_W-1:0]          digit,
  output logic [mrsd_pkg::FLAT_W-1:0]           flat_index,
  output logic                                  last
);

  localparam int NCELL = mrsd_pkg::CELLS_PER_SIDE * DEGREE;

  logic [mrsd_pkg::NSIDES-1:0][mrsd_pkg::RADIX_W-1:0] radix;
  mrsd_pkg::offsets_t offsets;
  mrsd_pkg::cell_t    stage [NCELL+1];
  logic               load_ok;
  logic               adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mrsd_pkg::NSIDES; i++) begin
        radix[i] <= mrsd_pkg::RADIX_RESET;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mrsd_pkg::REG_SIDE_SIZE_0: radix[0] <= mrsd_pkg::eff_radix(cfg_data);
        mrsd_pkg::REG_SIDE_SIZE_1: radix[1] <= mrsd_pkg::eff_radix(cfg_data);
        mrsd_pkg::REG_SIDE_SIZE_2: radix[2] <= mrsd_pkg::eff_radix(cfg_data);
        mrsd_pkg::REG_SIDE_SIZE_3: radix[3] <= mrsd_pkg::eff_radix(cfg_data);
        default: ;
      endcase
    end
  end

  assign offsets[0] = '0;
  assign offsets[1] = {1'b0, radix[0]};
  assign offsets[2] = offsets[1] + {1'b0, radix[1]};
  assign offsets[3] = offsets[2] + {1'b0, radix[2]};

  assign adv      = !stage[NCELL].valid || load_ok;
  assign in_ready = adv;

  always_comb begin
    stage[0].valid  = in_valid;
    stage[0].word   = position;
    stage[0].rem    = '0;
    stage[0].digits = '0;
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    localparam logic [mrsd_pkg::SIDE_W-1:0] SIDE =
      mrsd_pkg::SIDE_W'(DEGREE - 1 - k / mrsd_pkg::CELLS_PER_SIDE);
    localparam logic DEPOSIT =
      (k % mrsd_pkg::CELLS_PER_SIDE) == (mrsd_pkg::CELLS_PER_SIDE - 1);

    mrsd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .radix   (radix[SIDE]),
      .side    (SIDE),
      .deposit (DEPOSIT),
      .d_in    (stage[k]),
      .q       (stage[k+1])
    );
  end

  mrsd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .tail       (stage[NCELL]),
    .offsets    (offsets),
    .last_side  (mrsd_pkg::SIDE_W'(DEGREE - 1)),
    .load_ok    (load_ok),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .side_index (side_index),
    .digit      (digit),
    .flat_index (flat_index),
    .last       (last)
  );

endmodule

`default_nettype wire
